// File: hdl/ldt_pkg.sv
// ----------------------------------------------------------------------------
// ldt_pkg
// Shared types and codes for the load command byte tracker.
// ----------------------------------------------------------------------------
package ldt_pkg;

	localparam int SLOT_W = 3;
	localparam int ERR_W  = 3;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE    = 3'd0,
		ERR_RANGE   = 3'd1,
		ERR_FREE    = 3'd2,
		ERR_OVERRUN = 3'd3,
		ERR_ZERO    = 3'd4
	} err_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
	} pick_t;

endpackage

// File: hdl/ldt_req_if.sv
// ----------------------------------------------------------------------------
// ldt_req_if
// Per-cycle event transaction into the tracker.
// ----------------------------------------------------------------------------
interface ldt_req_if #(
	parameter int TAG_BITS  = 8,
	parameter int BYTE_BITS = 16
);
	logic                 valid;
	logic                 ready;
	logic                 alloc_valid;
	logic [BYTE_BITS-1:0] alloc_byte_count;
	logic [TAG_BITS-1:0]  alloc_tag;
	logic                 return_valid;
	logic [2:0]           return_slot;
	logic [BYTE_BITS-1:0] return_byte_count;
	logic                 complete_ready;

	modport source (
		output valid, alloc_valid, alloc_byte_count, alloc_tag,
		       return_valid, return_slot, return_byte_count, complete_ready,
		input  ready
	);

	modport sink (
		input  valid, alloc_valid, alloc_byte_count, alloc_tag,
		       return_valid, return_slot, return_byte_count, complete_ready,
		output ready
	);
endinterface

// File: hdl/ldt_rsp_if.sv
// ----------------------------------------------------------------------------
// ldt_rsp_if
// Per-cycle status transaction out of the tracker.
// ----------------------------------------------------------------------------
interface ldt_rsp_if #(
	parameter int TAG_BITS = 8
);
	logic                valid;
	logic                ready;
	logic                alloc_ready;
	logic [2:0]          alloc_slot;
	logic                complete_valid;
	logic [2:0]          complete_slot;
	logic [TAG_BITS-1:0] complete_tag;
	logic                busy_flag;
	logic [2:0]          error_code;

	modport source (
		output valid, alloc_ready, alloc_slot, complete_valid, complete_slot,
		       complete_tag, busy_flag, error_code,
		input  ready
	);

	modport sink (
		input  valid, alloc_ready, alloc_slot, complete_valid, complete_slot,
		       complete_tag, busy_flag, error_code,
		output ready
	);
endinterface

// File: hdl/ldt_pick.sv
// ----------------------------------------------------------------------------
// ldt_pick
// Lowest-index pick over a request vector: one-hot grant and slot number.
// ----------------------------------------------------------------------------
module ldt_pick import ldt_pkg::*; #(
	parameter int N = 5
) (
	input  logic [N-1:0] req,
	output logic [N-1:0] grant,
	output pick_t        pick
);

	assign grant = req & (~req + N'(1));

	always_comb begin
		pick.found = |req;
		pick.slot  = '0;
		for (int i = 0; i < N; i++) begin
			if (grant[i]) begin
				pick.slot = pick.slot | SLOT_W'(i);
			end
		end
	end

endmodule

// File: hdl/load_command_byte_tracker_top.sv
// ----------------------------------------------------------------------------
// load_command_byte_tracker_top
// Outstanding load command scoreboard with per-slot byte countdown.
//
// Each req transaction carries one cycle's events (allocation offer, memory
// return, completion handshake) and yields exactly one rsp transaction that
// reports the table as it stood before those events: lowest free slot, lowest
// valid slot with no bytes left and its tag, busy, and an error code. The
// events then update the table. The rsp transaction passes an input register
// on req acceptance, then a result register; one transaction is taken every
// cycle as long as rsp is drained, the table update and the rsp register load
// sharing the same edge. Slot numbers are reported in three bits.
// ----------------------------------------------------------------------------
module load_command_byte_tracker_top import ldt_pkg::*; #(
	parameter int ENTRY_COUNT = 5,
	parameter int TAG_BITS    = 8,
	parameter int BYTE_BITS   = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	ldt_req_if.sink    req,
	ldt_rsp_if.source  rsp
);

	logic                 valid_s1;
	logic                 alloc_valid_s1;
	logic [BYTE_BITS-1:0] alloc_byte_count_s1;
	logic [TAG_BITS-1:0]  alloc_tag_s1;
	logic                 return_valid_s1;
	logic [2:0]           return_slot_s1;
	logic [BYTE_BITS-1:0] return_byte_count_s1;
	logic                 complete_ready_s1;

	logic                 out_valid_q;
	logic                 alloc_ready_q;
	logic [SLOT_W-1:0]    alloc_slot_q;
	logic                 complete_valid_q;
	logic [SLOT_W-1:0]    complete_slot_q;
	logic [TAG_BITS-1:0]  complete_tag_q;
	logic                 busy_flag_q;
	err_t                 error_code_q;

	logic [ENTRY_COUNT-1:0] slot_valid_q;
	logic [TAG_BITS-1:0]    slot_tag_q  [ENTRY_COUNT];
	logic [BYTE_BITS-1:0]   slot_left_q [ENTRY_COUNT];

	logic                   advance;
	logic [ENTRY_COUNT-1:0] done_req;
	logic [ENTRY_COUNT-1:0] free_grant;
	logic [ENTRY_COUNT-1:0] done_grant;
	logic [ENTRY_COUNT-1:0] hit;
	pick_t                  free_pick;
	pick_t                  done_pick;
	logic [TAG_BITS-1:0]    done_tag;
	logic [BYTE_BITS-1:0]   old_left;
	logic                   old_valid;
	logic                   ret_ok;
	logic                   alloc_take;
	err_t                   err;

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_comb begin
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			done_req[i] = slot_valid_q[i] && (slot_left_q[i] == '0);
		end
	end

	ldt_pick #(.N(ENTRY_COUNT)) u_free_pick (
		.req   (~slot_valid_q),
		.grant (free_grant),
		.pick  (free_pick)
	);

	ldt_pick #(.N(ENTRY_COUNT)) u_done_pick (
		.req   (done_req),
		.grant (done_grant),
		.pick  (done_pick)
	);

	always_comb begin
		done_tag  = '0;
		old_left  = '0;
		old_valid = 1'b0;
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			hit[i] = return_valid_s1 && (int'(return_slot_s1) == i);
			if (done_grant[i]) begin
				done_tag = done_tag | slot_tag_q[i];
			end
			if (hit[i]) begin
				old_left  = old_left | slot_left_q[i];
				old_valid = old_valid | slot_valid_q[i];
			end
		end
	end

	always_comb begin
		err        = ERR_NONE;
		ret_ok     = 1'b0;
		alloc_take = alloc_valid_s1 && free_pick.found && (alloc_byte_count_s1 != '0);
		if (return_valid_s1) begin
			if (hit == '0) begin
				err = ERR_RANGE;
			end else if (!old_valid) begin
				err = ERR_FREE;
			end else if (return_byte_count_s1 > old_left) begin
				err = ERR_OVERRUN;
			end else begin
				ret_ok = 1'b1;
			end
		end
		if (err == ERR_NONE && alloc_valid_s1 && free_pick.found &&
			alloc_byte_count_s1 == '0) begin
			err = ERR_ZERO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			slot_valid_q <= '0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				for (int i = 0; i < ENTRY_COUNT; i++) begin
					if (done_grant[i] && complete_ready_s1) begin
						slot_valid_q[i] <= 1'b0;
					end
					if (alloc_take && free_grant[i]) begin
						slot_valid_q[i] <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			alloc_valid_s1       <= req.alloc_valid;
			alloc_byte_count_s1  <= req.alloc_byte_count;
			alloc_tag_s1         <= req.alloc_tag;
			return_valid_s1      <= req.return_valid;
			return_slot_s1       <= req.return_slot;
			return_byte_count_s1 <= req.return_byte_count;
			complete_ready_s1    <= req.complete_ready;
		end
		if (advance) begin
			alloc_ready_q    <= free_pick.found;
			alloc_slot_q     <= free_pick.slot;
			complete_valid_q <= done_pick.found;
			complete_slot_q  <= done_pick.slot;
			complete_tag_q   <= done_tag;
			busy_flag_q      <= |slot_valid_q;
			error_code_q     <= err;
			for (int i = 0; i < ENTRY_COUNT; i++) begin
				if (done_grant[i] && complete_ready_s1) begin
					slot_tag_q[i]  <= '0;
					slot_left_q[i] <= '0;
				end
				if (ret_ok && hit[i]) begin
					slot_left_q[i] <= old_left - return_byte_count_s1;
				end
				if (alloc_take && free_grant[i]) begin
					slot_tag_q[i]  <= alloc_tag_s1;
					slot_left_q[i] <= alloc_byte_count_s1;
				end
			end
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.alloc_ready    = alloc_ready_q;
	assign rsp.alloc_slot     = alloc_slot_q;
	assign rsp.complete_valid = complete_valid_q;
	assign rsp.complete_slot  = complete_slot_q;
	assign rsp.complete_tag   = complete_tag_q;
	assign rsp.busy_flag      = busy_flag_q;
	assign rsp.error_code     = error_code_q;

`ifndef ASSERT_OFF
	a_done_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && complete_valid_q |-> busy_flag_q)
		else $error("completion offered with empty table");

	a_full_means_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !alloc_ready_q |-> busy_flag_q)
		else $error("no free slot reported with empty table");

	a_zero_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && error_code_q == ERR_ZERO |-> alloc_ready_q)
		else $error("zero-byte flag without a free slot");

	a_complete_frees: assert property (@(posedge clk) disable iff (!arst_n)
		advance && complete_ready_s1 && done_pick.found |=>
		(slot_valid_q & $past(done_grant)) == '0)
		else $error("completed slot still valid");
`endif

endmodule

// File: sim/tb_load_command_byte_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_load_command_byte_tracker_top
// Self-checking bench for the load command byte tracker. One event
// transaction at most per tick goes in on req. A scoreboard model in the bench tracks
// the slot table and predicts the status transaction that comes back on rsp.
// Each status is checked field by field, in order. Directed ticks cover
// refusals, error codes and their priority, a full table, held and taken
// completions and draining. Random traffic then runs mostly legal command
// streams with random content, mixed with raw noise, under random stalls on
// both sides, but for one phase run without stalls.
// ----------------------------------------------------------------------------
module tb_load_command_byte_tracker_top;
	import ldt_pkg::*;

	localparam int ENTRY_COUNT = 5;
	localparam int TAG_BITS    = 8;
	localparam int BYTE_BITS   = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 50;

	typedef struct packed {
		logic                 alloc_valid;
		logic [BYTE_BITS-1:0] alloc_byte_count;
		logic [TAG_BITS-1:0]  alloc_tag;
		logic                 return_valid;
		logic [2:0]           return_slot;
		logic [BYTE_BITS-1:0] return_byte_count;
		logic                 complete_ready;
	} load_event_t;

	typedef struct packed {
		logic                alloc_ready;
		logic [2:0]          alloc_slot;
		logic                complete_valid;
		logic [2:0]          complete_slot;
		logic [TAG_BITS-1:0] complete_tag;
		logic                busy_flag;
		err_t                error_code;
	} tracker_status_t;

	logic clk;
	logic arst_n;

	ldt_req_if #(.TAG_BITS(TAG_BITS), .BYTE_BITS(BYTE_BITS)) req_bus ();
	ldt_rsp_if #(.TAG_BITS(TAG_BITS)) rsp_bus ();

	load_command_byte_tracker_top #(
		.ENTRY_COUNT (ENTRY_COUNT),
		.TAG_BITS    (TAG_BITS),
		.BYTE_BITS   (BYTE_BITS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	logic                 slot_busy [ENTRY_COUNT];
	logic [TAG_BITS-1:0]  slot_tag  [ENTRY_COUNT];
	logic [BYTE_BITS-1:0] slot_left [ENTRY_COUNT];

	tracker_status_t pending_status [$];
	int unsigned     mismatch_count = 0;
	int unsigned     cycle_count    = 0;
	int unsigned     idle_pct       = 21;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		rsp_bus.ready <= ($urandom_range(99) >= idle_pct);
	end

	function automatic tracker_status_t predict_tracker_status(input load_event_t ev);
		tracker_status_t st;
		logic            have_done;
		logic            ret_ok;
		logic [BYTE_BITS-1:0] old_left;
		st        = '0;
		have_done = 1'b0;
		ret_ok    = 1'b0;
		old_left  = '0;
		st.error_code = ERR_NONE;
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			if (slot_busy[i])
				st.busy_flag = 1'b1;
			if (!st.alloc_ready && !slot_busy[i]) begin
				st.alloc_ready = 1'b1;
				st.alloc_slot  = 3'(i);
			end
			if (!have_done && slot_busy[i] && slot_left[i] == '0) begin
				have_done        = 1'b1;
				st.complete_slot = 3'(i);
				st.complete_tag  = slot_tag[i];
			end
		end
		st.complete_valid = have_done;

		if (ev.return_valid) begin
			if (ev.return_slot >= ENTRY_COUNT) begin
				st.error_code = ERR_RANGE;
			end else if (!slot_busy[ev.return_slot]) begin
				st.error_code = ERR_FREE;
			end else if (ev.return_byte_count > slot_left[ev.return_slot]) begin
				st.error_code = ERR_OVERRUN;
			end else begin
				ret_ok   = 1'b1;
				old_left = slot_left[ev.return_slot];
			end
		end

		if (have_done && ev.complete_ready) begin
			slot_busy[st.complete_slot] = 1'b0;
			slot_tag[st.complete_slot]  = '0;
			slot_left[st.complete_slot] = '0;
		end

		if (ret_ok)
			slot_left[ev.return_slot] = old_left - ev.return_byte_count;

		if (ev.alloc_valid && st.alloc_ready) begin
			if (ev.alloc_byte_count == '0) begin
				if (st.error_code == ERR_NONE)
					st.error_code = ERR_ZERO;
			end else begin
				slot_busy[st.alloc_slot] = 1'b1;
				slot_tag[st.alloc_slot]  = ev.alloc_tag;
				slot_left[st.alloc_slot] = ev.alloc_byte_count;
			end
		end
		return st;
	endfunction

	function automatic load_event_t make_event(
		input logic av, input int unsigned ab, input int unsigned at,
		input logic rv, input int unsigned rs, input int unsigned rb,
		input logic cr
	);
		load_event_t ev;
		ev.alloc_valid       = av;
		ev.alloc_byte_count  = BYTE_BITS'(ab);
		ev.alloc_tag         = TAG_BITS'(at);
		ev.return_valid      = rv;
		ev.return_slot       = 3'(rs);
		ev.return_byte_count = BYTE_BITS'(rb);
		ev.complete_ready    = cr;
		return ev;
	endfunction

	function automatic load_event_t random_event();
		load_event_t ev;
		int unsigned start;
		int unsigned idx;
		int          pick;
		pick = -1;
		ev   = '0;
		if ($urandom_range(99) < 15) begin
			ev.alloc_valid       = 1'($urandom_range(1));
			ev.alloc_byte_count  = BYTE_BITS'($urandom);
			ev.alloc_tag         = TAG_BITS'($urandom);
			ev.return_valid      = 1'($urandom_range(1));
			ev.return_slot       = 3'($urandom);
			ev.return_byte_count = BYTE_BITS'($urandom);
			ev.complete_ready    = 1'($urandom_range(1));
			return ev;
		end

		ev.alloc_valid = ($urandom_range(99) < 60);
		ev.alloc_tag   = TAG_BITS'($urandom);
		case ($urandom_range(99)) inside
			[0:2]:   ev.alloc_byte_count = '0;
			[3:12]:  ev.alloc_byte_count = BYTE_BITS'($urandom_range(1, 65535));
			default: ev.alloc_byte_count = BYTE_BITS'($urandom_range(1, 16));
		endcase

		start = $urandom_range(ENTRY_COUNT - 1);
		for (int k = 0; k < ENTRY_COUNT; k++) begin
			idx = (start + k) % ENTRY_COUNT;
			if (pick < 0 && slot_busy[idx])
				pick = idx;
		end

		if ($urandom_range(99) < 8) begin
			ev.return_valid      = 1'b1;
			ev.return_slot       = 3'($urandom);
			ev.return_byte_count = BYTE_BITS'($urandom_range(0, 20));
		end else if (pick >= 0 && $urandom_range(99) < 70) begin
			ev.return_valid = 1'b1;
			ev.return_slot  = 3'(pick);
			if ($urandom_range(1))
				ev.return_byte_count = slot_left[pick];
			else
				ev.return_byte_count = BYTE_BITS'($urandom_range(0, slot_left[pick]));
		end
		ev.complete_ready = ($urandom_range(99) < 70);
		return ev;
	endfunction

	task automatic send_event(input load_event_t ev);
		while ($urandom_range(99) < idle_pct) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid             <= 1'b1;
		req_bus.alloc_valid       <= ev.alloc_valid;
		req_bus.alloc_byte_count  <= ev.alloc_byte_count;
		req_bus.alloc_tag         <= ev.alloc_tag;
		req_bus.return_valid      <= ev.return_valid;
		req_bus.return_slot       <= ev.return_slot;
		req_bus.return_byte_count <= ev.return_byte_count;
		req_bus.complete_ready    <= ev.complete_ready;
		do
			@(posedge clk);
		while (!req_bus.ready);
		pending_status.push_back(predict_tracker_status(ev));
	endtask

	task automatic report_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin : check_status
		tracker_status_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_status.size() == 0) begin
				mismatch_count++;
				$display("%0t ns: status transaction expected none, got one", $time);
			end else begin
				want = pending_status.pop_front();
				report_field("alloc_ready", want.alloc_ready, rsp_bus.alloc_ready);
				report_field("alloc_slot", want.alloc_slot, rsp_bus.alloc_slot);
				report_field("complete_valid", want.complete_valid, rsp_bus.complete_valid);
				report_field("complete_slot", want.complete_slot, rsp_bus.complete_slot);
				report_field("complete_tag", want.complete_tag, rsp_bus.complete_tag);
				report_field("busy_flag", want.busy_flag, rsp_bus.busy_flag);
				report_field("error_code", want.error_code, rsp_bus.error_code);
			end
		end
	end

	task automatic test_idle_after_reset();
		send_event(make_event(0, 0, 0, 0, 0, 0, 1));
	endtask

	task automatic test_allocation_refusals();
		send_event(make_event(1, 0, 'hAA, 0, 0, 0, 0));
		send_event(make_event(1, 0, 'h55, 1, 7, 'hFFFF, 0));
		send_event(make_event(0, 0, 0, 1, 0, 0, 1));
	endtask

	task automatic test_fill_and_return();
		send_event(make_event(1, 1, 'h00, 0, 0, 0, 0));
		send_event(make_event(1, 'hFFFF, 'hFF, 0, 0, 0, 0));
		send_event(make_event(1, 2, 'h5A, 1, 0, 2, 0));
		send_event(make_event(1, 'h8000, 'hA5, 1, 0, 1, 0));
		send_event(make_event(1, 3, 'h01, 0, 0, 0, 0));
		send_event(make_event(1, 5, 'h77, 1, 1, 'hFFFF, 0));
		send_event(make_event(1, 0, 'h33, 1, 0, 0, 1));
		send_event(make_event(1, 4, 'h3C, 1, 6, 1, 1));
		send_event(make_event(0, 0, 0, 1, 5, 0, 1));
	endtask

	task automatic test_drain();
		int target;
		for (int n = 0; n < 12; n++) begin
			target = -1;
			for (int i = ENTRY_COUNT - 1; i >= 0; i--)
				if (slot_busy[i] && slot_left[i] != '0)
					target = i;
			if (target >= 0)
				send_event(make_event(0, 0, 0, 1, target, int'(slot_left[target]), 1));
			else
				send_event(make_event(0, 0, 0, 0, 0, 0, 1));
		end
	endtask

	task automatic test_random_traffic(input int unsigned count, input int unsigned pct);
		idle_pct = pct;
		repeat (count)
			send_event(random_event());
		idle_pct = 21;
	endtask

	initial begin
		arst_n                    <= 1'b0;
		req_bus.valid             <= 1'b0;
		req_bus.alloc_valid       <= 1'b0;
		req_bus.alloc_byte_count  <= '0;
		req_bus.alloc_tag         <= '0;
		req_bus.return_valid      <= 1'b0;
		req_bus.return_slot       <= '0;
		req_bus.return_byte_count <= '0;
		req_bus.complete_ready    <= 1'b0;
		for (int i = 0; i < ENTRY_COUNT; i++) begin
			slot_busy[i] = 1'b0;
			slot_tag[i]  = '0;
			slot_left[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_after_reset();
		test_allocation_refusals();
		test_fill_and_return();
		test_drain();
		test_random_traffic(400, 21);
		test_random_traffic(250, 0);
		test_random_traffic(350, 21);

		req_bus.valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: files.f
hdl/ldt_pkg.sv
hdl/ldt_req_if.sv
hdl/ldt_rsp_if.sv
hdl/ldt_pick.sv
hdl/load_command_byte_tracker_top.sv
sim/tb_load_command_byte_tracker_top.sv
